// ===== hw/rtl/uart_gtd_pkg.sv =====
// Shared types and constants for the UART gap-timeout deframer.
package uart_gtd_pkg;

   localparam int unsigned SLOT_BYTES_DEF = 64;
   localparam int unsigned RING_SLOTS_DEF = 8;

   localparam int unsigned GAP_W   = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 16;

   localparam logic [GAP_W-1:0] GAP_TICKS_RST = 16'd30;
   localparam logic [GAP_W-1:0] GAP_MAX       = 16'hFFFF;

   typedef enum logic {
      CSR_LINK_CONNECTED = 1'b0,
      CSR_GAP_TICKS      = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_BYTE = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_DATA
   } state_type;

endpackage

// ===== hw/rtl/uart_gap_timeout_deframer_top.sv =====
// UART receiver deframer: gap-timed frame closing into a ring of slots.
//
// Usage:
//  - req channel: one request is either a received byte (req_action = byte)
//    or one timer tick. Bytes are stored in a local frame store; nothing is
//    returned for them. A tick that closes a frame starts emission.
//  - rsp channel: one response per emitted byte: length high, length low,
//    then the stored data bytes, tagged with slot index and slot offset.
//    The final byte carries rsp_last_of_frame and rsp_keepalive_restart.
//  - csr channel: always ready; index 0 link_connected, 1 gap_ticks.
//  - Emission: a closing tick emits byte_count + 2 bytes, one byte per cycle
//    while the receiver is not stalling, from the output register, paced by
//    the single store read port; req_ready is low throughout emission.
//  - A stalled receiver holds the output register; the sequencer waits.
//  - Reset clears counters, gap timer, slot index and link_connected, and
//    sets gap_ticks to GAP_TICKS_RST. The frame store is not cleared; only
//    written entries are emitted.
module uart_gap_timeout_deframer_top
   import uart_gtd_pkg::*;
#(
   parameter int unsigned SLOT_BYTES = SLOT_BYTES_DEF,
   parameter int unsigned RING_SLOTS = RING_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [BYTE_W-1:0]             req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [$clog2(RING_SLOTS)-1:0] rsp_slot_index,
   output logic [$clog2(SLOT_BYTES)-1:0] rsp_slot_offset,
   output logic [BYTE_W-1:0]             rsp_out_byte,
   output logic                          rsp_last_of_frame,
   output logic                          rsp_keepalive_restart,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [GAP_W-1:0]              csr_wdata
);

   localparam int unsigned STORE_DEPTH = SLOT_BYTES - 2;
   localparam int unsigned CNT_W  = $clog2(SLOT_BYTES);
   localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int unsigned SLOT_W = $clog2(RING_SLOTS);
   localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(STORE_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(RING_SLOTS - 1);

   state_type           state_ff, state_in;
   logic                link_ff, link_in;
   logic [GAP_W-1:0]    gap_ticks_ff, gap_ticks_in;
   logic [CNT_W-1:0]    byte_count_ff, byte_count_in;
   logic                gap_running_ff, gap_running_in;
   logic [GAP_W-1:0]    gap_count_ff, gap_count_in;
   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    offset_ff, offset_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                last_ff, last_in;

   logic [BYTE_W-1:0]   store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0]   rd_data_ff;
   logic                store_we;

   logic                req_acc, out_free;
   logic [GAP_W-1:0]    gap_inc;
   logic [LEN_W-1:0]    frame_len;
   logic [CNT_W-1:0]    data_offset;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign gap_inc   = (gap_count_ff < GAP_MAX) ? gap_count_ff + 1'b1 : gap_count_ff;
   assign frame_len   = LEN_W'(byte_count_ff);
   assign data_offset = CNT_W'(idx_ff) + CNT_W'(2);

   always_comb begin
      state_in       = state_ff;
      link_in        = link_ff;
      gap_ticks_in   = gap_ticks_ff;
      byte_count_in  = byte_count_ff;
      gap_running_in = gap_running_ff;
      gap_count_in   = gap_count_ff;
      write_slot_in  = write_slot_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      offset_in      = offset_ff;
      out_byte_in    = out_byte_ff;
      last_in        = last_ff;
      store_we       = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LINK_CONNECTED: link_in      = csr_wdata[0];
            CSR_GAP_TICKS:      gap_ticks_in = csr_wdata;
            default:            ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_acc) begin
               if (action_type'(req_action) == ACT_BYTE) begin
                  if (link_ff) begin
                     if (byte_count_ff == '0) begin
                        gap_running_in = 1'b1;
                     end
                     gap_count_in = '0;
                  end
                  if ((link_ff || req_rx_byte != '0) && byte_count_ff < DEPTH_C) begin
                     store_we      = 1'b1;
                     byte_count_in = byte_count_ff + 1'b1;
                  end
               end else if (gap_running_ff) begin
                  gap_count_in = gap_inc;
                  if (gap_inc >= gap_ticks_ff) begin
                     state_in = ST_LEN_HI;
                  end
               end
            end
         end
         ST_LEN_HI: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               offset_in    = CNT_W'(0);
               out_byte_in  = frame_len[LEN_W-1 -: BYTE_W];
               last_in      = 1'b0;
               state_in     = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               offset_in    = CNT_W'(1);
               out_byte_in  = frame_len[BYTE_W-1:0];
               last_in      = (byte_count_ff == '0);
               state_in     = last_in ? ST_IDLE : ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               offset_in    = data_offset;
               out_byte_in  = rd_data_ff;
               last_in      = (CNT_W'(idx_ff) + 1'b1 == byte_count_ff);
               if (last_in) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff != ST_IDLE && state_in == ST_IDLE) begin
         byte_count_in  = '0;
         gap_running_in = 1'b0;
         gap_count_in   = '0;
         write_slot_in  = (write_slot_ff == SLOT_LAST) ? '0 : write_slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         link_ff        <= 1'b0;
         gap_ticks_ff   <= GAP_TICKS_RST;
         byte_count_ff  <= '0;
         gap_running_ff <= 1'b0;
         gap_count_ff   <= '0;
         write_slot_ff  <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         link_ff        <= link_in;
         gap_ticks_ff   <= gap_ticks_in;
         byte_count_ff  <= byte_count_in;
         gap_running_ff <= gap_running_in;
         gap_count_ff   <= gap_count_in;
         write_slot_ff  <= write_slot_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff   <= offset_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   // Frame store: written in idle, read one entry ahead of emission.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[byte_count_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= store_mem[idx_in];
   end

   // Slot index of the frame in flight; slot advances only as it returns to idle.
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   assign rsp_slot_in = (state_ff != ST_IDLE && out_free) ? write_slot_ff : rsp_slot_ff;
   always_ff @(posedge clock) begin
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_slot_index        = rsp_slot_ff;
   assign rsp_slot_offset       = offset_ff;
   assign rsp_out_byte          = out_byte_ff;
   assign rsp_last_of_frame     = last_ff;
   assign rsp_keepalive_restart = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= DEPTH_C)
      else $error("byte count beyond store depth");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> byte_count_ff != '0 && gap_running_ff)
      else $error("emission without collected bytes or running timer");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA && out_free && last_in |=>
         state_ff == ST_IDLE && byte_count_ff == '0 && !gap_running_ff)
      else $error("frame close did not clear state");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> CNT_W'(idx_ff) < byte_count_ff)
      else $error("store read beyond collected bytes");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the UART gap-timeout deframer, with a frame predictor.
`timescale 1ns / 1ps

module tb;
   import uart_gtd_pkg::*;

   localparam int STORE_DEPTH    = SLOT_BYTES_DEF - 2;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic [2:0] slot;
      logic [5:0] offset;
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACT_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_slot_index;
   logic [5:0]  rsp_slot_offset;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_frame;
   logic        rsp_keepalive_restart;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_LINK_CONNECTED;
   logic [15:0] csr_wdata = 16'h0000;

   // predictor state
   logic [7:0]  held_bytes [STORE_DEPTH];
   int          held_count = 0;
   bit          gap_timer_on = 1'b0;
   logic [15:0] gap_elapsed = 16'h0000;
   int          next_slot = 0;
   bit          link_up = 1'b0;
   logic [15:0] gap_limit = GAP_TICKS_RST;

   frame_byte_type expected_frame_bytes [$];
   int          applied_requests = 0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;

   uart_gap_timeout_deframer_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_slot_offset       (rsp_slot_offset),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_last_of_frame     (rsp_last_of_frame),
      .rsp_keepalive_restart (rsp_keepalive_restart),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   function automatic void hold_byte(logic [7:0] data);
      if (held_count < STORE_DEPTH) begin
         held_bytes[held_count] = data;
         held_count++;
      end
   endfunction

   // Works out the frame bytes a request closes, if any.
   function automatic void deframe_request(action_type act, logic [7:0] data);
      frame_byte_type rec;
      if (act == ACT_BYTE) begin
         if (!link_up) begin
            if (data != 8'h00)
               hold_byte(data);
         end else begin
            if (held_count == 0)
               gap_timer_on = 1'b1;
            gap_elapsed = 16'h0000;
            hold_byte(data);
         end
      end else if (gap_timer_on) begin
         if (gap_elapsed != GAP_MAX)
            gap_elapsed++;
         if (gap_elapsed >= gap_limit) begin
            rec.slot   = 3'(next_slot);
            rec.offset = 6'd0;
            rec.data   = 8'(held_count >> 8);
            rec.last   = 1'b0;
            expected_frame_bytes.push_back(rec);
            rec.offset = 6'd1;
            rec.data   = 8'(held_count);
            rec.last   = (held_count == 0);
            expected_frame_bytes.push_back(rec);
            for (int i = 0; i < held_count; i++) begin
               rec.offset = 6'(i + 2);
               rec.data   = held_bytes[i];
               rec.last   = (i == held_count - 1);
               expected_frame_bytes.push_back(rec);
            end
            next_slot    = (next_slot + 1) % RING_SLOTS_DEF;
            held_count   = 0;
            gap_timer_on = 1'b0;
            gap_elapsed  = 16'h0000;
         end
      end
   endfunction

   task automatic send_request(action_type act, logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= data;
      do @(posedge clock); while (!req_ready);
      applied_requests++;
      deframe_request(act, data);
   endtask

   task automatic write_register(csr_index_type idx, logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_frame_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LINK_CONNECTED)
         link_up = value[0];
      else
         gap_limit = value;
   endtask

   task automatic close_open_frame();
      while (gap_timer_on)
         send_request(ACT_TICK, 8'($urandom));
   endtask

   // Ticks between bytes stay below the gap so the frame is not cut short.
   task automatic send_random_frame(int len, bit close);
      int gaps;
      for (int n = 0; n < len; n++) begin
         send_request(ACT_BYTE, ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
         gaps = 0;
         if (gap_limit > 1)
            gaps = $urandom_range((gap_limit - 1 > 3) ? 3 : gap_limit - 1);
         repeat (gaps) send_request(ACT_TICK, 8'($urandom));
      end
      if (close)
         close_open_frame();
   endtask

   task automatic test_basic_frames();
      write_register(CSR_LINK_CONNECTED, 16'd1);
      write_register(CSR_GAP_TICKS, 16'd1);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_TICK, 8'hFF);
      write_register(CSR_GAP_TICKS, 16'd3);
      send_request(ACT_BYTE, 8'h80);
      send_request(ACT_TICK, 8'h00);
      send_request(ACT_TICK, 8'h00);
      send_request(ACT_BYTE, 8'h01);
      close_open_frame();
   endtask

   task automatic test_gap_extremes();
      write_register(CSR_GAP_TICKS, 16'd0);
      send_request(ACT_BYTE, 8'h5A);
      send_request(ACT_TICK, 8'h00);
      write_register(CSR_GAP_TICKS, GAP_MAX);
      send_request(ACT_BYTE, 8'hA5);
      send_request(ACT_BYTE, 8'h3C);
      repeat (5) send_request(ACT_TICK, 8'h00);
      // lowering the limit under the elapsed count closes on the next tick
      write_register(CSR_GAP_TICKS, 16'd2);
      send_request(ACT_TICK, 8'h00);
   endtask

   task automatic test_disconnect_mid_frame();
      write_register(CSR_GAP_TICKS, 16'd4);
      send_request(ACT_BYTE, 8'h11);
      write_register(CSR_LINK_CONNECTED, 16'd0);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'h22);
      close_open_frame();
   endtask

   task automatic test_ignored_requests();
      send_request(ACT_TICK, 8'h00);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_TICK, 8'hFF);
   endtask

   task automatic run_random_traffic(int quota, bit with_full_store);
      int target;
      int pick;
      int len;
      target = applied_requests + quota;
      if (!link_up)
         write_register(CSR_LINK_CONNECTED, 16'd1);
      if (with_full_store) begin
         write_register(CSR_GAP_TICKS, 16'd1);
         send_random_frame($urandom_range(STORE_DEPTH, STORE_DEPTH + 4), 1'b1);
      end
      while (applied_requests < target) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            repeat ($urandom_range(1, 3)) send_request(ACT_TICK, 8'($urandom));
         end else if (pick == 1) begin
            send_random_frame($urandom_range(1, 5), 1'b0);
            write_register(CSR_LINK_CONNECTED, 16'd0);
            repeat ($urandom_range(1, 4))
               send_request(ACT_BYTE, ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
            close_open_frame();
            write_register(CSR_LINK_CONNECTED, 16'd1);
         end else begin
            if ($urandom_range(3) == 0)
               write_register(CSR_GAP_TICKS, 16'($urandom_range(1, 6)));
            len = ($urandom_range(19) == 0) ? $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 2)
                                            : $urandom_range(1, 8);
            send_random_frame(len, 1'b1);
         end
      end
   endtask

   // Bytes held while disconnected keep the timer from ever starting again,
   // so this runs last.
   task automatic test_stuck_store();
      write_register(CSR_GAP_TICKS, 16'd1);
      write_register(CSR_LINK_CONNECTED, 16'd0);
      send_request(ACT_BYTE, 8'h7F);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'h01);
      write_register(CSR_LINK_CONNECTED, 16'd1);
      send_request(ACT_BYTE, 8'hC3);
      repeat (3) send_request(ACT_TICK, 8'h00);
   endtask

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frame_bytes.size() == 0) begin
            $display("%0t: expected no response, got slot %0d off %0d byte %02h", $time,
                     rsp_slot_index, rsp_slot_offset, rsp_out_byte);
            mismatch_count++;
         end else begin
            want = expected_frame_bytes.pop_front();
            if (rsp_slot_index !== want.slot || rsp_slot_offset !== want.offset ||
                rsp_out_byte !== want.data || rsp_last_of_frame !== want.last ||
                rsp_keepalive_restart !== want.last) begin
               $display("%0t: expected slot %0d off %0d byte %02h last %0b ka %0b,",
                        $time, want.slot, want.offset, want.data, want.last, want.last);
               $display("%0t: got slot %0d off %0d byte %02h last %0b ka %0b",
                        $time, rsp_slot_index, rsp_slot_offset, rsp_out_byte,
                        rsp_last_of_frame, rsp_keepalive_restart);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 34;
      receiver_idle_pct = 50;
      test_basic_frames();
      test_gap_extremes();
      test_disconnect_mid_frame();
      test_ignored_requests();
      run_random_traffic(80, 1'b1);

      sender_idle_pct   = 50;
      receiver_idle_pct = 34;
      run_random_traffic(45, 1'b0);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random_traffic(45, 1'b0);
      test_stuck_store();

      req_valid <= 1'b0;
      while (expected_frame_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/uart_gtd_pkg.sv
hw/rtl/uart_gap_timeout_deframer_top.sv
sim/tb.sv
